/* rtl/one_shot_timer_slot_table_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the one-shot timer slot table
// Clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_SLOT_TABLE_MACROS_SVH
`define ONE_SHOT_TIMER_SLOT_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define OSTST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define OSTST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define OSTST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define OSTST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/ostst_pkg.sv */
// ----------------------------------------------------------------------------
// ostst_pkg
// Shared types and codes of the one-shot timer slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package ostst_pkg;

	localparam int MS_W        = 32;
	localparam int TASK_PORT_W = 8;
	localparam int SLOT_PORT_W = 5;

	typedef logic [MS_W-1:0] ms_t;

	localparam logic ACT_SCHED  = 1'b0;
	localparam logic ACT_RUN    = 1'b1;
	localparam logic KIND_SCHED = 1'b0;
	localparam logic KIND_RUN   = 1'b1;

endpackage

`default_nettype wire

/* rtl/ostst_cell.sv */
// ----------------------------------------------------------------------------
// ostst_cell
// One timer slot of the ring: valid bit, task tag and deadline, loaded from
// the neighbor cell on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ostst_cell
	import ostst_pkg::*;
#(
	parameter int TW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire logic          nbr_valid,
	input  wire logic [TW-1:0] nbr_tag,
	input  wire ms_t           nbr_deadline,
	output logic               valid,
	output logic [TW-1:0]      tag,
	output ms_t                deadline
);

	logic          valid_q;
	logic [TW-1:0] tag_q;
	ms_t           deadline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nbr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q      <= nbr_tag;
			deadline_q <= nbr_deadline;
		end
	end

	assign valid    = valid_q;
	assign tag      = tag_q;
	assign deadline = deadline_q;

endmodule

`default_nettype wire

/* rtl/one_shot_timer_slot_table.sv */
// ----------------------------------------------------------------------------
// one_shot_timer_slot_table
// One-shot timer slots held in a ring of cells. Schedule stores a task in the
// lowest free slot; run fires and frees every expired slot in slot order.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  command   start / busy      action, now_ms, delay_ms, task_id
//  result    strobe (1 cycle)  kind, accepted, slot_index, deadline_ms,
//                              fired, fired_task, fire_time_ms, last
//
//  Every command keeps busy high while the ring rotates one slot past the head
//  cell per cycle, then while a done state closes the beat.
//  Results are registered: each comes in the cycle after it is decided, at most one per cycle.
//  Reset clears all valid bits at once; the table is ready right after it.
//  Results cannot be held off; strobe marks each one for a single cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "one_shot_timer_slot_table_macros.svh"

module one_shot_timer_slot_table
	import ostst_pkg::*;
#(
	parameter int SLOT_COUNT   = 20,
	parameter int TASK_ID_BITS = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   action,
	input  wire ms_t                    now_ms,
	input  wire ms_t                    delay_ms,
	input  wire logic [TASK_PORT_W-1:0] task_id,
	output logic                        strobe,
	output logic                        kind,
	output logic                        accepted,
	output logic [SLOT_PORT_W-1:0]      slot_index,
	output ms_t                         deadline_ms,
	output logic                        fired,
	output logic [TASK_PORT_W-1:0]      fired_task,
	output ms_t                         fire_time_ms,
	output logic                        last
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int TW = (TASK_ID_BITS < TASK_PORT_W) ? TASK_ID_BITS : TASK_PORT_W;
	localparam logic [IW-1:0] LAST_STEP = IW'(SLOT_COUNT - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] step_q;
	logic          found_q;
	logic          pend_q;
	logic          op_q;
	ms_t           now_q;
	ms_t           deadline_q;
	logic [TW-1:0] task_q;
	logic [IW-1:0] slot_q;
	logic [IW-1:0] pend_slot_q;
	logic [TW-1:0] pend_task_q;

	logic          cv [SLOT_COUNT];
	logic [TW-1:0] ct [SLOT_COUNT];
	ms_t           cd [SLOT_COUNT];

	logic          shift;
	logic          fb_valid;
	logic [TW-1:0] fb_tag;
	ms_t           fb_deadline;
	logic          take;
	logic          fire;
	logic          accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign shift  = (state_q == ST_SCAN);

	// ring: cell i loads from cell i+1, the tail loads the updated head
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == SLOT_COUNT - 1) begin : g_tail
			ostst_cell #(.TW(TW)) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.shift        (shift),
				.nbr_valid    (fb_valid),
				.nbr_tag      (fb_tag),
				.nbr_deadline (fb_deadline),
				.valid        (cv[i]),
				.tag          (ct[i]),
				.deadline     (cd[i])
			);
		end else begin : g_body
			ostst_cell #(.TW(TW)) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.shift        (shift),
				.nbr_valid    (cv[i+1]),
				.nbr_tag      (ct[i+1]),
				.nbr_deadline (cd[i+1]),
				.valid        (cv[i]),
				.tag          (ct[i]),
				.deadline     (cd[i])
			);
		end
	end

	always_comb begin
		fb_valid    = cv[0];
		fb_tag      = ct[0];
		fb_deadline = cd[0];
		take        = 1'b0;
		fire        = 1'b0;
		if (state_q == ST_SCAN) begin
			if (op_q == ACT_SCHED) begin
				if (!found_q && !cv[0]) begin
					take        = 1'b1;
					fb_valid    = 1'b1;
					fb_tag      = task_q;
					fb_deadline = deadline_q;
				end
			end else if (cv[0] && (now_q >= cd[0])) begin
				fire     = 1'b1;
				fb_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						step_q  <= '0;
						found_q <= 1'b0;
						pend_q  <= 1'b0;
					end
				end
				ST_SCAN: begin
					step_q <= step_q + 1'b1;
					if (take) begin
						found_q <= 1'b1;
					end
					if (fire) begin
						pend_q <= 1'b1;
					end
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= action;
			now_q      <= now_ms;
			deadline_q <= now_ms + delay_ms;
			task_q     <= task_id[TW-1:0];
		end
		if (take) begin
			slot_q <= step_q;
		end
		if (fire) begin
			pend_slot_q <= step_q;
			pend_task_q <= ct[0];
		end
	end

	// result select; a fire flushes the previous pending fire as not last
	logic [IW+SLOT_PORT_W-1:0] slot_ext_found;
	logic [IW+SLOT_PORT_W-1:0] slot_ext_pend;
	logic [TW+TASK_PORT_W-1:0] task_ext_pend;

	assign slot_ext_found = {{SLOT_PORT_W{1'b0}}, slot_q};
	assign slot_ext_pend  = {{SLOT_PORT_W{1'b0}}, pend_slot_q};
	assign task_ext_pend  = {{TASK_PORT_W{1'b0}}, pend_task_q};

	logic                   emit;
	logic                   e_kind;
	logic                   e_accepted;
	logic [SLOT_PORT_W-1:0] e_slot;
	ms_t                    e_deadline;
	logic                   e_fired;
	logic [TASK_PORT_W-1:0] e_task;
	ms_t                    e_ftime;
	logic                   e_last;

	always_comb begin
		emit       = 1'b0;
		e_kind     = KIND_RUN;
		e_accepted = 1'b0;
		e_slot     = '0;
		e_deadline = '0;
		e_fired    = 1'b0;
		e_task     = '0;
		e_ftime    = '0;
		e_last     = 1'b1;
		if (state_q == ST_SCAN) begin
			if (fire && pend_q) begin
				emit    = 1'b1;
				e_slot  = slot_ext_pend[SLOT_PORT_W-1:0];
				e_fired = 1'b1;
				e_task  = task_ext_pend[TASK_PORT_W-1:0];
				e_ftime = now_q;
				e_last  = 1'b0;
			end
		end else if (state_q == ST_DONE) begin
			emit = 1'b1;
			if (op_q == ACT_SCHED) begin
				e_kind     = KIND_SCHED;
				e_accepted = found_q;
				e_slot     = found_q ? slot_ext_found[SLOT_PORT_W-1:0] : '0;
				e_deadline = deadline_q;
			end else if (pend_q) begin
				e_slot  = slot_ext_pend[SLOT_PORT_W-1:0];
				e_fired = 1'b1;
				e_task  = task_ext_pend[TASK_PORT_W-1:0];
				e_ftime = now_q;
			end
		end
	end

	logic strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind         <= e_kind;
			accepted     <= e_accepted;
			slot_index   <= e_slot;
			deadline_ms  <= e_deadline;
			fired        <= e_fired;
			fired_task   <= e_task;
			fire_time_ms <= e_ftime;
			last         <= e_last;
		end
	end

	assign strobe = strobe_q;

	`OSTST_ASSERT_NXT(a_accept_scans, clk, arst_n, accept, state_q == ST_SCAN,
		"accepted command did not start a scan")
	`OSTST_ASSERT_IMP(a_strobe_from_work, clk, arst_n, strobe, $past(state_q) != ST_IDLE,
		"result strobe without a command in progress")
	`OSTST_ASSERT_IMP(a_sched_single, clk, arst_n, strobe && (kind == KIND_SCHED), last && !fired,
		"schedule answer must be a single last beat")
	`OSTST_ASSERT_IMP(a_found_sched_only, clk, arst_n, found_q && busy, op_q != ACT_RUN,
		"slot taken during a run command")
	`OSTST_ASSERT_IMP(a_done_after_full_turn, clk, arst_n, state_q == ST_DONE,
		$past(step_q) == LAST_STEP, "scan ended before a full ring turn")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: one-shot timer slot table testbench
// Drives schedule and run commands through start/busy and predicts every
// answer from a private copy of the slot table. Each strobed result is
// compared field by field with the oldest predicted answer. Directed tests
// cover field extremes, deadline wrap, an empty run, a full table and a run
// that fires every slot. Random traffic then follows, under three sender
// idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
	import ostst_pkg::*;

	localparam int SLOTS      = 20;
	localparam int CYCLE_CAP  = 400000;
	localparam int BEATS_EACH = 75;

	typedef struct {
		logic                   kind;
		logic                   accepted;
		logic [SLOT_PORT_W-1:0] slot;
		ms_t                    deadline;
		logic                   fired;
		logic [TASK_PORT_W-1:0] tid;
		ms_t                    fire_at;
		logic                   last;
	} answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   action = ACT_SCHED;
	ms_t                    now_ms = '0;
	ms_t                    delay_ms = '0;
	logic [TASK_PORT_W-1:0] task_id = '0;
	logic                   busy;
	logic                   strobe;
	logic                   kind;
	logic                   accepted;
	logic [SLOT_PORT_W-1:0] slot_index;
	ms_t                    deadline_ms;
	logic                   fired;
	logic [TASK_PORT_W-1:0] fired_task;
	ms_t                    fire_time_ms;
	logic                   last;

	logic                   slot_live [SLOTS];
	logic [TASK_PORT_W-1:0] slot_owner [SLOTS];
	ms_t                    slot_due [SLOTS];
	answer_t                pending_answers [$];
	int                     mismatches = 0;
	int                     cycles = 0;
	int                     idle_pct = 0;
	ms_t                    clock_ms = '0;

	one_shot_timer_slot_table #(
		.SLOT_COUNT  (SLOTS),
		.TASK_ID_BITS(8)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.now_ms      (now_ms),
		.delay_ms    (delay_ms),
		.task_id     (task_id),
		.strobe      (strobe),
		.kind        (kind),
		.accepted    (accepted),
		.slot_index  (slot_index),
		.deadline_ms (deadline_ms),
		.fired       (fired),
		.fired_task  (fired_task),
		.fire_time_ms(fire_time_ms),
		.last        (last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// schedule takes the lowest free slot; run frees every expired slot in order
	task automatic apply_command(input logic act, input ms_t at_ms, input ms_t dly,
			input logic [TASK_PORT_W-1:0] tid);
		answer_t a;
		int      n;
		ms_t     due;
		a = '{KIND_SCHED, 1'b0, '0, '0, 1'b0, '0, '0, 1'b1};
		if (act == ACT_SCHED) begin
			due = at_ms + dly;
			a.deadline = due;
			for (int i = 0; i < SLOTS; i++) begin
				if (!slot_live[i]) begin
					slot_live[i] = 1'b1;
					slot_owner[i] = tid;
					slot_due[i] = due;
					a.accepted = 1'b1;
					a.slot = i[SLOT_PORT_W-1:0];
					break;
				end
			end
			pending_answers.push_back(a);
		end else begin
			n = 0;
			a.kind = KIND_RUN;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_live[i] && at_ms >= slot_due[i]) begin
					a.slot = i[SLOT_PORT_W-1:0];
					a.fired = 1'b1;
					a.tid = slot_owner[i];
					a.fire_at = at_ms;
					a.last = 1'b0;
					pending_answers.push_back(a);
					slot_live[i] = 1'b0;
					slot_owner[i] = '0;
					slot_due[i] = '0;
					n++;
				end
			end
			if (n == 0) begin
				a = '{KIND_RUN, 1'b0, '0, '0, 1'b0, '0, '0, 1'b1};
				pending_answers.push_back(a);
			end else begin
				pending_answers[pending_answers.size() - 1].last = 1'b1;
			end
		end
	endtask

	task automatic send_beat(input logic act, input ms_t at_ms, input ms_t dly,
			input logic [TASK_PORT_W-1:0] tid);
		int gap;
		start <= 1'b1;
		action <= act;
		now_ms <= at_ms;
		delay_ms <= dly;
		task_id <= tid;
		do @(posedge clk); while (busy);
		apply_command(act, at_ms, dly, tid);
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(1, 30);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_answers
		answer_t e;
		if (arst_n && strobe) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind=%0d slot=%0d fired=%0d task=%h",
						kind, slot_index, fired, fired_task);
			end else begin
				e = pending_answers.pop_front();
				if (kind !== e.kind || accepted !== e.accepted || slot_index !== e.slot ||
						deadline_ms !== e.deadline || fired !== e.fired ||
						fired_task !== e.tid || fire_time_ms !== e.fire_at ||
						last !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("exp: kind=%0d acc=%0d slot=%0d dl=%h ",
							e.kind, e.accepted, e.slot, e.deadline,
							"fired=%0d task=%h ft=%h last=%0d",
							e.fired, e.tid, e.fire_at, e.last);
						$display("got: kind=%0d acc=%0d slot=%0d dl=%h ",
							kind, accepted, slot_index, deadline_ms,
							"fired=%0d task=%h ft=%h last=%0d",
							fired, fired_task, fire_time_ms, last);
					end
				end
			end
		end
	end

	// zero deadline, wrapped deadline, both firing at time zero, then an empty run
	task automatic test_extremes();
		send_beat(ACT_SCHED, 32'h0000_0000, 32'h0000_0000, 8'h00);
		send_beat(ACT_SCHED, 32'hFFFF_FFFF, 32'h0000_0001, 8'hFF);
		send_beat(ACT_RUN, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
		send_beat(ACT_RUN, 32'h0000_0000, 32'h0000_0000, 8'h00);
	endtask

	// fill every slot, drop one more, then fire all slots in one run
	task automatic test_full_table();
		for (int i = 0; i < SLOTS; i++)
			send_beat(ACT_SCHED, 32'd1000 * i,
				(i % 3 == 0) ? $urandom() : $urandom_range(0, 900),
				TASK_PORT_W'($urandom_range(0, 255)));
		send_beat(ACT_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hA5);
		send_beat(ACT_RUN, 32'hFFFF_FFFF, '0, '0);
		wait_drain();
	endtask

	task automatic test_random_traffic(input int beats);
		logic act;
		ms_t  dly;
		for (int n = 0; n < beats; n++) begin
			if ($urandom_range(99) < 85) begin
				clock_ms = clock_ms + $urandom_range(0, 60);
				act = ($urandom_range(99) < 60) ? ACT_SCHED : ACT_RUN;
				dly = ($urandom_range(3) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 100);
				send_beat(act, clock_ms, dly, TASK_PORT_W'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(1) == 0)
					clock_ms = $urandom();
				else
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
				send_beat(1'($urandom_range(0, 1)), $urandom(), $urandom(),
					TASK_PORT_W'($urandom_range(0, 255)));
			end
			if (n % 30 == 29)
				wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_owner[i] = '0;
			slot_due[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 27;
		test_extremes();
		test_full_table();
		test_random_traffic(BEATS_EACH);
		idle_pct = 77;
		test_random_traffic(BEATS_EACH);
		idle_pct = 0;
		test_random_traffic(BEATS_EACH);

		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
